// ===== hw/rtl/ilid_pkg.sv =====
// Shared types, codes and sizes for the indexed list block.
package ilid_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = 6;
    localparam int CNT_W  = 7;
    localparam int WORD_W = 32;

    // Request modes
    localparam logic [2:0] MODE_APPEND = 3'd0;
    localparam logic [2:0] MODE_POP    = 3'd1;
    localparam logic [2:0] MODE_INSERT = 3'd2;
    localparam logic [2:0] MODE_DELETE = 3'd3;
    localparam logic [2:0] MODE_GET    = 3'd4;
    localparam logic [2:0] MODE_SET    = 3'd5;

    // Result status codes
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_FULL   = 2'd1;
    localparam logic [1:0] STAT_EMPTY  = 2'd2;
    localparam logic [1:0] STAT_BADPOS = 2'd3;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    typedef struct packed {
        logic [2:0]        mode;
        logic [ADDR_W-1:0] position;
        logic [WORD_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [WORD_W-1:0] read_value;
        logic [CNT_W-1:0]  count;
        logic              is_empty;
        logic [1:0]        status;
    } res_t;

    // Memory read address source
    typedef enum logic [1:0] {
        RA_POS  = 2'd0,
        RA_LAST = 2'd1,
        RA_IDX  = 2'd2
    } rd_sel_t;

    // Memory write address source
    typedef enum logic [1:0] {
        WA_POS = 2'd0,
        WA_CNT = 2'd1,
        WA_UP  = 2'd2,
        WA_DN  = 2'd3
    } wa_sel_t;

    // Memory write data source
    typedef enum logic {
        WD_VAL = 1'b0,
        WD_MEM = 1'b1
    } wd_sel_t;

    typedef enum logic [2:0] {
        IDX_HOLD = 3'd0,
        IDX_POS1 = 3'd1,
        IDX_LAST = 3'd2,
        IDX_INC  = 3'd3,
        IDX_DEC  = 3'd4
    } idx_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD = 2'd0,
        CNT_INC  = 2'd1,
        CNT_DEC  = 2'd2
    } cnt_op_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic       load_req;
        logic       rd_en;
        rd_sel_t    rd_sel;
        logic       wr_en;
        wa_sel_t    wa_sel;
        wd_sel_t    wd_sel;
        idx_op_t    idx_op;
        cnt_op_t    cnt_op;
        logic       rv_load;
        logic       rv_clear;
        logic       st_load;
        logic [1:0] st;
        logic       out_load;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic [2:0] mode;
        logic       full;
        logic       empty;
        logic       pos_gt_cnt;
        logic       pos_ge_cnt;
        logic       pos_eq_cnt;
        logic       idx_eq_pos;
        logic       idx_lt_cnt;
        logic       idx_last;
    } dp_sts_t;

endpackage

// ===== hw/rtl/ilid_dp.sv =====
// Datapath: element memory, count, sweep index, request and result registers.
module ilid_dp
    import ilid_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  req_t    s_data,
    input  dp_cmd_t cmd,
    output dp_sts_t sts,
    output res_t    m_data
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    req_t              req_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [WORD_W-1:0] rv_reg;
    logic [1:0]        st_reg;
    res_t              res_reg;

    logic [CNT_W-1:0]  pos_ext;
    logic [CNT_W-1:0]  cnt_m1;
    logic [CNT_W-1:0]  idx_p1;
    logic [CNT_W-1:0]  idx_m1;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;

    assign pos_ext = CNT_W'(req_reg.position);
    assign cnt_m1  = count_reg - CNT_W'(1);
    assign idx_p1  = idx_reg + CNT_W'(1);
    assign idx_m1  = idx_reg - CNT_W'(1);

    // Select memory addresses and write data
    always_comb begin
        unique case (cmd.rd_sel)
            RA_POS:  rd_addr = req_reg.position;
            RA_LAST: rd_addr = cnt_m1[ADDR_W-1:0];
            RA_IDX:  rd_addr = idx_reg[ADDR_W-1:0];
            default: rd_addr = req_reg.position;
        endcase
        unique case (cmd.wa_sel)
            WA_POS:  wr_addr = req_reg.position;
            WA_CNT:  wr_addr = count_reg[ADDR_W-1:0];
            WA_UP:   wr_addr = idx_p1[ADDR_W-1:0];
            WA_DN:   wr_addr = idx_m1[ADDR_W-1:0];
            default: wr_addr = req_reg.position;
        endcase
        wr_data = (cmd.wd_sel == WD_MEM) ? rd_data_reg : req_reg.value;
    end

    // Single write port, registered read port
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Next count and sweep index
    always_comb begin
        unique case (cmd.cnt_op)
            CNT_HOLD: count_next = count_reg;
            CNT_INC:  count_next = count_reg + CNT_W'(1);
            CNT_DEC:  count_next = cnt_m1;
            default:  count_next = count_reg;
        endcase
        unique case (cmd.idx_op)
            IDX_HOLD: idx_next = idx_reg;
            IDX_POS1: idx_next = pos_ext + CNT_W'(1);
            IDX_LAST: idx_next = cnt_m1;
            IDX_INC:  idx_next = idx_p1;
            IDX_DEC:  idx_next = idx_m1;
            default:  idx_next = idx_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (cmd.load_req) begin
            req_reg <= s_data;
        end
        if (cmd.rv_clear) begin
            rv_reg <= '0;
        end else if (cmd.rv_load) begin
            rv_reg <= rd_data_reg;
        end
        if (cmd.st_load) begin
            st_reg <= cmd.st;
        end
        if (cmd.out_load) begin
            res_reg.read_value <= rv_reg;
            res_reg.count      <= count_reg;
            res_reg.is_empty   <= (count_reg == '0);
            res_reg.status     <= st_reg;
        end
    end

    // Flags for the controller
    always_comb begin
        sts.mode       = req_reg.mode;
        sts.full       = (count_reg == DEPTH_CNT);
        sts.empty      = (count_reg == '0);
        sts.pos_gt_cnt = (pos_ext > count_reg);
        sts.pos_ge_cnt = (pos_ext >= count_reg);
        sts.pos_eq_cnt = (pos_ext == count_reg);
        sts.idx_eq_pos = (idx_reg == pos_ext);
        sts.idx_lt_cnt = (idx_reg < count_reg);
        sts.idx_last   = (idx_p1 == count_reg);
    end

    assign m_data = res_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_CNT)
        else $error("element count exceeds depth");

    a_inc_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cnt_op == CNT_INC |-> count_reg != DEPTH_CNT)
        else $error("count increment on a full list");

    a_dec_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cnt_op == CNT_DEC |-> count_reg != '0)
        else $error("count decrement on an empty list");

endmodule

// ===== hw/rtl/ilid_ctrl.sv =====
// Controller: checks each request and sequences memory reads, writes and shifts.
module ilid_ctrl
    import ilid_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_EVAL = 7'b0000010,
        S_RDV  = 7'b0000100,
        S_SHRD = 7'b0001000,
        S_SHWR = 7'b0010000,
        S_INSV = 7'b0100000,
        S_FIN  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    // Next state and datapath commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RA_POS;
        cmd.wa_sel = WA_POS;
        cmd.wd_sel = WD_VAL;
        cmd.idx_op = IDX_HOLD;
        cmd.cnt_op = CNT_HOLD;
        cmd.st     = STAT_OK;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    state_next   = S_EVAL;
                end
            end
            S_EVAL: begin
                cmd.rv_clear = 1'b1;
                cmd.st_load  = 1'b1;
                state_next   = S_FIN;
                case (sts.mode)
                    MODE_APPEND: begin
                        if (sts.full) begin
                            cmd.st = STAT_FULL;
                        end else begin
                            cmd.wr_en  = 1'b1;
                            cmd.wa_sel = WA_CNT;
                            cmd.cnt_op = CNT_INC;
                        end
                    end
                    MODE_POP: begin
                        if (sts.empty) begin
                            cmd.st = STAT_EMPTY;
                        end else begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RA_LAST;
                            cmd.cnt_op = CNT_DEC;
                            state_next = S_RDV;
                        end
                    end
                    MODE_INSERT: begin
                        if (sts.full) begin
                            cmd.st = STAT_FULL;
                        end else if (sts.pos_gt_cnt) begin
                            cmd.st = STAT_BADPOS;
                        end else if (sts.pos_eq_cnt) begin
                            cmd.wr_en  = 1'b1;
                            cmd.cnt_op = CNT_INC;
                        end else begin
                            cmd.idx_op = IDX_LAST;
                            state_next = S_SHRD;
                        end
                    end
                    MODE_DELETE, MODE_GET: begin
                        if (sts.empty) begin
                            cmd.st = STAT_EMPTY;
                        end else if (sts.pos_ge_cnt) begin
                            cmd.st = STAT_BADPOS;
                        end else begin
                            cmd.rd_en  = 1'b1;
                            cmd.idx_op = IDX_POS1;
                            state_next = S_RDV;
                        end
                    end
                    MODE_SET: begin
                        if (sts.empty) begin
                            cmd.st = STAT_EMPTY;
                        end else if (sts.pos_ge_cnt) begin
                            cmd.st = STAT_BADPOS;
                        end else begin
                            cmd.wr_en = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_RDV: begin
                // capture the word read; delete then closes the gap
                cmd.rv_load = 1'b1;
                state_next  = S_FIN;
                if (sts.mode == MODE_DELETE) begin
                    if (sts.idx_lt_cnt) begin
                        state_next = S_SHRD;
                    end else begin
                        cmd.cnt_op = CNT_DEC;
                    end
                end
            end
            S_SHRD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RA_IDX;
                state_next = S_SHWR;
            end
            S_SHWR: begin
                cmd.wr_en  = 1'b1;
                cmd.wd_sel = WD_MEM;
                if (sts.mode == MODE_INSERT) begin
                    cmd.wa_sel = WA_UP;
                    if (sts.idx_eq_pos) begin
                        state_next = S_INSV;
                    end else begin
                        cmd.idx_op = IDX_DEC;
                        state_next = S_SHRD;
                    end
                end else begin
                    cmd.wa_sel = WA_DN;
                    if (sts.idx_last) begin
                        cmd.cnt_op = CNT_DEC;
                        state_next = S_FIN;
                    end else begin
                        cmd.idx_op = IDX_INC;
                        state_next = S_SHRD;
                    end
                end
            end
            S_INSV: begin
                cmd.wr_en  = 1'b1;
                cmd.cnt_op = CNT_INC;
                state_next = S_FIN;
            end
            S_FIN: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("controller state not one-hot");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !(m_valid_reg && !m_ready))
        else $error("result overwritten before it was taken");

    a_accept_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == S_EVAL && !m_valid_reg == !$past(m_valid_next))
        else $error("accepted transaction not evaluated");

endmodule

// ===== hw/rtl/indexed_list_insert_delete.sv =====
// Top level of the indexed list: controller plus datapath.
//
// Holds an ordered list of up to 64 32-bit words in a memory with one write
// port and one registered read port (one write and one registered read per
// cycle) and answers every request with one result. Append, set, insert at
// the end of the list, refused requests and unused modes are done in the
// evaluate state; get and pop also pass through the read-capture state.
// Insert below the count and delete also move the words behind the position,
// since the shift sweeps the memory one word per read/write pair. s_ready
// rises in the cycle after the result is loaded, even if it has not yet been
// taken, so the next transaction can be accepted while that result still
// waits. Memory contents after reset are unknown; only entries below the
// count are ever read.
module indexed_list_insert_delete
    import ilid_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output res_t m_data
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    ilid_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ilid_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_data  (m_data)
    );

endmodule

// ===== tb/sv/ilid_checker.sv =====
// Checker for the indexed list: predicts every result and compares it on the result channel.
module ilid_checker
    import ilid_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    input  logic s_ready,
    input  req_t s_data,
    input  logic m_valid,
    input  logic m_ready,
    input  res_t m_data,
    output int   fail_count,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [WORD_W-1:0] list_words [DEPTH];
    int unsigned       list_len;
    res_t              expected_results [$];
    res_t              oldest_expected;
    int unsigned       results_seen;

    // Print one mismatch line and count it
    task automatic report_mismatch(input string msg);
        $display("%0t ns: result %0d: %s", $time, results_seen, msg);
        fail_count++;
    endtask

    // Apply one request to the list and return the result it should produce
    function automatic res_t apply_request(input req_t req);
        res_t        res;
        int unsigned n;
        int unsigned p;
        res = '0;
        n   = list_len;
        p   = req.position;
        case (req.mode)
            MODE_APPEND: begin
                if (n >= DEPTH) begin
                    res.status = STAT_FULL;
                end else begin
                    list_words[n] = req.value;
                    list_len      = n + 1;
                end
            end
            MODE_POP: begin
                if (n == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    res.read_value = list_words[n-1];
                    list_len       = n - 1;
                end
            end
            MODE_INSERT: begin
                // full check wins over the position check
                if (n >= DEPTH) begin
                    res.status = STAT_FULL;
                end else if (p > n) begin
                    res.status = STAT_BADPOS;
                end else begin
                    for (int i = n; i > p; i--) list_words[i] = list_words[i-1];
                    list_words[p] = req.value;
                    list_len      = n + 1;
                end
            end
            MODE_DELETE: begin
                if (n == 0) begin
                    res.status = STAT_EMPTY;
                end else if (p >= n) begin
                    res.status = STAT_BADPOS;
                end else begin
                    res.read_value = list_words[p];
                    for (int i = p; i + 1 < n; i++) list_words[i] = list_words[i+1];
                    list_len = n - 1;
                end
            end
            MODE_GET: begin
                if (n == 0) begin
                    res.status = STAT_EMPTY;
                end else if (p >= n) begin
                    res.status = STAT_BADPOS;
                end else begin
                    res.read_value = list_words[p];
                end
            end
            MODE_SET: begin
                if (n == 0) begin
                    res.status = STAT_EMPTY;
                end else if (p >= n) begin
                    res.status = STAT_BADPOS;
                end else begin
                    list_words[p] = req.value;
                end
            end
            default: begin
                // unused modes leave everything as it is
            end
        endcase
        res.count    = CNT_W'(list_len);
        res.is_empty = (list_len == 0);
        return res;
    endfunction

    // Check results against the oldest prediction, then predict for new requests
    always @(posedge aclk) begin
        if (!aresetn) begin
            list_len = 0;
            expected_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch("result transaction with nothing expected");
                end else begin
                    oldest_expected = expected_results.pop_front();
                    if (m_data.read_value !== oldest_expected.read_value)
                        report_mismatch($sformatf("read_value got %h expected %h",
                                        m_data.read_value, oldest_expected.read_value));
                    if (m_data.count !== oldest_expected.count)
                        report_mismatch($sformatf("count got %0d expected %0d",
                                        m_data.count, oldest_expected.count));
                    if (m_data.is_empty !== oldest_expected.is_empty)
                        report_mismatch($sformatf("is_empty got %b expected %b",
                                        m_data.is_empty, oldest_expected.is_empty));
                    if (m_data.status !== oldest_expected.status)
                        report_mismatch($sformatf("status got %0d expected %0d",
                                        m_data.status, oldest_expected.status));
                end
            end
            if (s_valid && s_ready)
                expected_results.push_back(apply_request(s_data));
        end
        pending <= expected_results.size();
    end

endmodule

// ===== tb/sv/tb_indexed_list_insert_delete.sv =====
// Top of the indexed list testbench: clock, reset, request and result traffic, verdict.
module tb_indexed_list_insert_delete;
    import ilid_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum {PH_FILL, PH_DRAIN, PH_MIXED} traffic_phase_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    res_t m_data;

    int             fail_count;
    int             pending;
    bit             no_idle;
    int             list_level;
    traffic_phase_t phase;
    int             phase_left;
    req_t           next_req;

    indexed_list_insert_delete dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    ilid_checker checker_inst (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic req_t make_req(input logic [2:0] mode, input logic [ADDR_W-1:0] pos,
                                      input logic [WORD_W-1:0] val);
        req_t r;
        r.mode     = mode;
        r.position = pos;
        r.value    = val;
        return r;
    endfunction

    // Offer one request after a random gap and hold it until accepted
    task automatic send_request(input req_t req);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // track the fill level to steer the random traffic
        case (req.mode)
            MODE_APPEND: if (list_level < DEPTH) list_level++;
            MODE_POP:    if (list_level > 0) list_level--;
            MODE_INSERT: if (list_level < DEPTH && req.position <= list_level) list_level++;
            MODE_DELETE: if (list_level > 0 && req.position < list_level) list_level--;
            default: ;
        endcase
    endtask

    // Drop valid and hold until every predicted result has come back
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // Draw a request shaped by the current traffic phase
    task automatic pick_random_request(output req_t req);
        int roll;
        if (phase_left == 0) begin
            phase      = traffic_phase_t'($urandom_range(0, 2));
            phase_left = $urandom_range(40, 160);
            no_idle    = ($urandom_range(0, 3) == 0);
        end
        phase_left--;
        roll = $urandom_range(0, 99);
        case (phase)
            PH_FILL:  req.mode = roll < 45 ? MODE_APPEND : roll < 88 ? MODE_INSERT
                                : 3'($urandom_range(0, 5));
            PH_DRAIN: req.mode = roll < 45 ? MODE_POP : roll < 88 ? MODE_DELETE
                                : 3'($urandom_range(0, 5));
            default:  req.mode = roll < 3 ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
        endcase
        // mostly legal positions, some anywhere in the field
        if ($urandom_range(0, 4) == 0)
            req.position = ADDR_W'($urandom_range(0, 63));
        else if (req.mode == MODE_INSERT)
            req.position = ADDR_W'($urandom_range(0, list_level));
        else if (list_level > 0)
            req.position = ADDR_W'($urandom_range(0, list_level - 1));
        else
            req.position = '0;
        roll = $urandom_range(0, 9);
        req.value = roll == 0 ? 32'hFFFF_FFFF : roll == 1 ? 32'h0 : 32'($urandom);
    endtask

    // Result side: stall a random number of cycles before taking each transaction
    initial begin
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // Request side: directed cases, then phased random traffic
    initial begin
        list_level = 0;
        phase_left = 0;
        no_idle    = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // empty list: empty refusals come before any position check; insert at 1 is a bad position
        send_request(make_req(MODE_POP,    6'd0,  32'h1234_5678));
        send_request(make_req(MODE_DELETE, 6'd63, 32'h0));
        send_request(make_req(MODE_GET,    6'd63, 32'h0));
        send_request(make_req(MODE_SET,    6'd0,  32'hFFFF_FFFF));
        send_request(make_req(MODE_INSERT, 6'd1,  32'hDEAD_BEEF));
        // build a short list, inserting at the front, in the middle and at the end
        send_request(make_req(MODE_INSERT, 6'd0,  32'hFFFF_FFFF));
        send_request(make_req(MODE_APPEND, 6'd63, 32'h0000_0000));
        send_request(make_req(MODE_INSERT, 6'd2,  32'h7F80_0000));
        send_request(make_req(MODE_INSERT, 6'd1,  32'h8000_0001));
        // reads at the edges of the list and past it
        send_request(make_req(MODE_GET,    6'd0,  32'h0));
        send_request(make_req(MODE_GET,    6'd3,  32'h0));
        send_request(make_req(MODE_GET,    6'd4,  32'h0));
        send_request(make_req(MODE_GET,    6'd63, 32'hFFFF_FFFF));
        // overwrite in and out of range
        send_request(make_req(MODE_SET,    6'd1,  32'hA5A5_A5A5));
        send_request(make_req(MODE_SET,    6'd4,  32'h5A5A_5A5A));
        // removals
        send_request(make_req(MODE_DELETE, 6'd4,  32'h0));
        send_request(make_req(MODE_DELETE, 6'd0,  32'h0));
        send_request(make_req(MODE_DELETE, 6'd2,  32'h0));
        // unused modes change nothing
        send_request(make_req(3'd6, 6'd0,  32'hFFFF_FFFF));
        send_request(make_req(3'd7, 6'd63, 32'h0));
        send_request(make_req(MODE_POP,    6'd0,  32'h0));
        send_request(make_req(MODE_GET,    6'd0,  32'h0));
        wait_for_drain();

        for (int i = 0; i < 1800; i++) begin
            pick_random_request(next_req);
            send_request(next_req);
            if (i == 900) wait_for_drain();
        end

        wait_for_drain();
        repeat (200) @(posedge aclk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog for a hung handshake
    initial begin
        #30ms;
        $display("FAILURE");
        $finish;
    end

endmodule
